// ===== hw/rtl/ehd_pkg.sv =====
// Shared types, entity tables and a helper function for the entity decoder.
package ehd_pkg;

  localparam int unsigned NumEnt      = 5;
  localparam int unsigned HoldDepth   = 5;
  localparam int unsigned BurstDepth  = 6;
  localparam int unsigned PatLen      = 6;

  localparam logic [7:0] CharAmp  = 8'h26;  // '&'

  // Entity spellings, lower case; unused tail bytes are zero.
  localparam logic [7:0] EntPat [NumEnt][PatLen] = '{
    '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // &amp;
    '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},  // &apos;
    '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},  // &quot;
    '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // &gt;
    '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00}   // &lt;
  };
  localparam logic [2:0] EntLen [NumEnt] = '{3'd5, 3'd6, 3'd6, 3'd4, 3'd4};
  localparam logic [7:0] EntVal [NumEnt] = '{8'h26, 8'h27, 8'h22, 8'h3e, 8'h3c};

  // Bytes released by one input word, oldest in entry 0.
  typedef struct packed {
    logic [BurstDepth-1:0][7:0] bytes;
    logic [2:0]                 cnt;
    logic                       last;
  } burst_t;

  // Case-blind compare for letters, exact compare for everything else.
  function automatic logic byte_eq(logic [7:0] c, logic [7:0] p);
    logic res;
    if (p inside {[8'h61:8'h7a]}) begin
      res = (c == p) || (c == (p - 8'd32));
    end else begin
      res = (c == p);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/ehd_in_if.sv =====
// Input word channel: one encoded byte with its end-of-string flag.
interface ehd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// ===== hw/rtl/ehd_out_if.sv =====
// Output word channel: one decoded byte with its end markers.
interface ehd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_char, output run_end, output string_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_end, input string_end,
                  output ready);
endinterface

// ===== hw/rtl/html_entity_decoder.sv =====
// Top level of the HTML/XML entity decoder.
// Decodes &amp; &apos; &quot; &gt; and &lt; (letters in any case) in a byte
// stream, one word per byte, with in_last marking the end of each string.
// Plain bytes pass through the output register, one word per cycle while the
// output is ready. An ampersand and the bytes that may still complete an
// entity are held back and produce no output; a full match emits the single
// decoded byte, and a mismatch or end of string releases the held text
// literally, up to six bytes for one input word. Each input word fills the
// output register with its burst, which drains one byte per cycle while the
// output is ready; the next input word is taken in the cycle the last byte of
// the previous burst leaves. run_end flags the last byte of each burst and
// string_end the last byte caused by a word with in_last set.
module html_entity_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  ehd_in_if.sink    in_i,
  ehd_out_if.source out_o
);

  ehd_pkg::burst_t burst;
  logic            can_load;
  logic            accept;

  // Take a word whenever the output register is free or frees this cycle.
  assign in_i.ready = can_load;
  assign accept     = in_i.valid && can_load;

  // Match against the entity table and build the burst for this word.
  ehd_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (in_i.in_char),
    .last_i   (in_i.in_last),
    .burst_o  (burst)
  );

  // Hold the burst and hand it out a byte at a time.
  ehd_burst u_burst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .burst_i    (burst),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

// ===== hw/rtl/ehd_scan.sv =====
// Entity matcher: held bytes, live-entity mask and the burst for each word.
module ehd_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      char_i,
  input  logic            last_i,
  output ehd_pkg::burst_t burst_o
);

  logic [7:0]                   held_q [ehd_pkg::HoldDepth];
  logic [7:0]                   held_d [ehd_pkg::HoldDepth];
  logic [2:0]                   cnt_q, cnt_d;
  logic [ehd_pkg::NumEnt-1:0]   alive_q, alive_d;

  logic [ehd_pkg::NumEnt-1:0]   hit;
  logic [7:0]                   fval;
  logic [2:0]                   flen;
  logic                         is_amp;
  logic [ehd_pkg::BurstDepth-1:0][7:0] lst;

  always_comb begin
    for (int e = 0; e < ehd_pkg::NumEnt; e++) begin
      hit[e] = alive_q[e] && (cnt_q < ehd_pkg::EntLen[e]) &&
               ehd_pkg::byte_eq(char_i, ehd_pkg::EntPat[e][cnt_q]);
    end
    // Lowest entity index wins.
    fval = '0;
    flen = '0;
    for (int e = ehd_pkg::NumEnt - 1; e >= 0; e--) begin
      if (hit[e]) begin
        fval = ehd_pkg::EntVal[e];
        flen = ehd_pkg::EntLen[e];
      end
    end
  end

  // Held bytes followed by the current byte.
  always_comb begin
    for (int i = 0; i < ehd_pkg::HoldDepth; i++) begin
      lst[i] = (3'(i) < cnt_q) ? held_q[i] : char_i;
    end
    lst[ehd_pkg::BurstDepth-1] = char_i;
  end

  assign is_amp = (char_i == ehd_pkg::CharAmp);

  always_comb begin
    held_d        = held_q;
    cnt_d         = cnt_q;
    alive_d       = alive_q;
    burst_o.bytes = lst;
    burst_o.cnt   = '0;
    burst_o.last  = last_i;
    if (cnt_q == 3'd0) begin
      if (is_amp && !last_i) begin
        held_d[0] = char_i;
        cnt_d     = 3'd1;
        alive_d   = '1;
      end else begin
        burst_o.cnt = 3'd1;
      end
    end else if (|hit) begin
      if (cnt_q + 3'd1 == flen) begin
        burst_o.bytes[0] = fval;
        burst_o.cnt      = 3'd1;
        cnt_d            = 3'd0;
      end else if (last_i) begin
        burst_o.cnt = cnt_q + 3'd1;
        cnt_d       = 3'd0;
      end else begin
        for (int i = 0; i < ehd_pkg::HoldDepth; i++) begin
          if (3'(i) == cnt_q) held_d[i] = char_i;
        end
        cnt_d   = cnt_q + 3'd1;
        alive_d = hit;
      end
    end else begin
      // Mismatch: release held text; a new ampersand opens a fresh match.
      if (is_amp && !last_i) begin
        burst_o.cnt = cnt_q;
        held_d[0]   = char_i;
        cnt_d       = 3'd1;
        alive_d     = '1;
      end else begin
        burst_o.cnt = cnt_q + 3'd1;
        cnt_d       = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      alive_q <= '0;
    end else if (accept_i) begin
      cnt_q   <= cnt_d;
      alive_q <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

// ===== hw/rtl/ehd_burst.sv =====
// Output register: holds one word's burst and shifts it out a byte at a time.
module ehd_burst (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  ehd_pkg::burst_t burst_i,
  output logic            can_load_o,
  ehd_out_if.source       out_o
);

  logic [ehd_pkg::BurstDepth-1:0][7:0] buf_q, buf_d;
  logic [2:0]                          rem_q, rem_d;
  logic                                last_q;
  logic                                pop;

  assign out_o.valid      = (rem_q != 3'd0);
  assign out_o.out_char   = buf_q[0];
  assign out_o.run_end    = (rem_q == 3'd1);
  assign out_o.string_end = (rem_q == 3'd1) && last_q;

  assign pop        = out_o.valid && out_o.ready;
  assign can_load_o = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_o.ready);

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    if (load_i) begin
      buf_d = burst_i.bytes;
      rem_d = burst_i.cnt;
    end else if (pop) begin
      for (int i = 0; i < ehd_pkg::BurstDepth - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      rem_d = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (load_i) begin
      last_q <= burst_i.last;
    end
  end

endmodule
